### design/assert_macros.svh
// assertion macros used by the reassembler core
// expects clk and rst_n in scope at the point of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SBR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SBR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBR_ASSERT(lbl, prop, msg)
`define SBR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### design/sbr_pkg.sv
// shared constants and types for the stream byte reassembler
// no dependencies
package sbr_pkg;

  localparam int SBR_CAPACITY = 4096;
  localparam int SBR_IDX_W    = 64;
  localparam int SBR_BYTE_W   = 8;
  localparam int SBR_ROOM_W   = 13;

  typedef enum logic {
    SBR_ACT_SEGMENT = 1'b0,
    SBR_ACT_DRAIN   = 1'b1
  } sbr_action_t;

endpackage

### design/stream_byte_reassembler_top.sv
// stream byte reassembler: rebuilds an in-order byte stream from indexed bytes
// depends on sbr_pkg, sbr_core and sbr_out_reg
//
// input channel: in_valid / in_stall, one item per transfer; action segment
// stores one byte (or marks the stream end), action drain emits the byte at
// the next expected index when it is present
// result channel: out_valid / out_stall, exactly one result per input item,
// in input order
// path: an item taken is held in the core input register, and its result is loaded into the output register
// throughput: one item per cycle while the input does not stall, set by the
// single write port of the valid map and byte store, used at most once per item
// reset: rst_n is synchronous and active low; after it a clearing pass writes
// every valid map entry, with in_stall high
// stall: a stalled result holds in the output register; the input stalls in
// the clearing pass and while its held item cannot enter the result register
module stream_byte_reassembler_top
  import sbr_pkg::*;
#(
  parameter int CAPACITY = SBR_CAPACITY
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_action,
  input  logic [SBR_IDX_W-1:0]                 in_byte_index,
  input  logic [SBR_BYTE_W-1:0]                in_byte_value,
  input  logic                                 in_has_byte,
  input  logic                                 in_final_mark,
  input  logic [SBR_ROOM_W-1:0]                in_stream_room,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_out_valid,
  output logic [SBR_BYTE_W-1:0]                out_out_byte,
  output logic                                 out_stream_closed,
  output logic [$clog2(CAPACITY + 1)-1:0]      out_pending_bytes
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int RES_W = 2 + SBR_BYTE_W + CNT_W;

  logic                  res_valid;
  logic                  res_ready;
  logic                  res_out_valid;
  logic [SBR_BYTE_W-1:0] res_out_byte;
  logic                  res_stream_closed;
  logic [CNT_W-1:0]      res_pending_bytes;
  logic [RES_W-1:0]      res_data;
  logic [RES_W-1:0]      out_data;

  sbr_core #(
    .CAPACITY (CAPACITY)
  ) u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_byte_index     (in_byte_index),
    .in_byte_value     (in_byte_value),
    .in_has_byte       (in_has_byte),
    .in_final_mark     (in_final_mark),
    .in_stream_room    (in_stream_room),
    .res_valid         (res_valid),
    .res_ready         (res_ready),
    .res_out_valid     (res_out_valid),
    .res_out_byte      (res_out_byte),
    .res_stream_closed (res_stream_closed),
    .res_pending_bytes (res_pending_bytes)
  );

  assign res_data = {res_out_valid, res_out_byte, res_stream_closed, res_pending_bytes};

  sbr_out_reg #(
    .W (RES_W)
  ) u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (res_valid),
    .load_ready (res_ready),
    .load_data  (res_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  assign out_out_valid     = out_data[RES_W-1];
  assign out_out_byte      = out_data[RES_W-2 -: SBR_BYTE_W];
  assign out_stream_closed = out_data[CNT_W];
  assign out_pending_bytes = out_data[CNT_W-1:0];

endmodule

### design/sbr_out_reg.sv
// result register between the reassembler core and the output channel
// depends on sbr_pkg for the default payload width
module sbr_out_reg
  import sbr_pkg::*;
#(
  parameter int W = 2 + SBR_BYTE_W + $clog2(SBR_CAPACITY + 1)
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load_valid,
  output logic         load_ready,
  input  logic [W-1:0] load_data,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [W-1:0] out_data
);

  logic         valid_r;
  logic [W-1:0] data_r;

  assign load_ready = !valid_r || !out_stall;
  assign out_valid  = valid_r;
  assign out_data   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_ready) begin
      valid_r <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      data_r <= load_data;
    end
  end

endmodule

### design/sbr_core.sv
// reassembler core: input register, valid map and byte store, stream state
// depends on sbr_pkg and assert_macros.svh
`include "assert_macros.svh"
module sbr_core
  import sbr_pkg::*;
#(
  parameter int CAPACITY = SBR_CAPACITY,
  localparam int SLOT_W  = $clog2(CAPACITY),
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_action,
  input  logic [SBR_IDX_W-1:0]  in_byte_index,
  input  logic [SBR_BYTE_W-1:0] in_byte_value,
  input  logic                  in_has_byte,
  input  logic                  in_final_mark,
  input  logic [SBR_ROOM_W-1:0] in_stream_room,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic                  res_out_valid,
  output logic [SBR_BYTE_W-1:0] res_out_byte,
  output logic                  res_stream_closed,
  output logic [CNT_W-1:0]      res_pending_bytes
);

  localparam int SUM_W = SLOT_W + 1;
  localparam int RW    = (SBR_ROOM_W > CNT_W) ? SBR_ROOM_W : CNT_W;

  logic                  valid_map_r  [CAPACITY];
  logic [SBR_BYTE_W-1:0] byte_store_r [CAPACITY];

  logic                  clear_r;
  logic [SLOT_W-1:0]     clr_addr_r;

  logic                  s1_valid_r;
  logic                  s1_action_r;
  logic [SBR_IDX_W-1:0]  s1_idx_r;
  logic [SBR_BYTE_W-1:0] s1_val_r;
  logic                  s1_has_r;
  logic                  s1_fin_r;
  logic [SBR_ROOM_W-1:0] s1_room_r;
  logic [SLOT_W-1:0]     s1_slot_r;
  logic                  valid_a_r;
  logic                  valid_b_r;
  logic [SBR_BYTE_W-1:0] byte_b_r;

  logic [SBR_IDX_W-1:0]  next_index_r, next_index_nxt;
  logic [SLOT_W-1:0]     next_slot_r, next_slot_nxt;
  logic [CNT_W-1:0]      pending_r, pending_nxt;
  logic                  end_known_r, end_known_nxt;
  logic [SBR_IDX_W-1:0]  end_index_r, end_index_nxt;
  logic                  closed_r, closed_nxt;

  logic                  accept;
  logic                  exec;
  logic                  drain;
  logic                  new_end;
  logic [SBR_IDX_W-1:0]  off;
  logic [RW-1:0]         room_ext;
  logic [RW-1:0]         room_eff;
  logic                  in_win;
  logic                  past_end;
  logic                  store;
  logic                  emit;

  logic [SBR_IDX_W-1:0]  off0;
  logic                  off0_ok;
  logic [SUM_W-1:0]      slot_sum;
  logic [SLOT_W-1:0]     slot_a;
  logic [SLOT_W-1:0]     slot_b;

  logic                  vwr_en;
  logic [SLOT_W-1:0]     vwr_addr;
  logic                  vwr_data;

  assign exec     = s1_valid_r && res_ready;
  assign in_stall = !rst_n || clear_r || (s1_valid_r && !res_ready);
  assign accept   = in_valid && !in_stall;

  // slot of the arriving byte, relative to the slot of next_index
  always_comb begin
    off0     = in_byte_index - next_index_r;
    off0_ok  = off0 <= SBR_IDX_W'(CAPACITY);
    slot_sum = SUM_W'(next_slot_r) + off0[SUM_W-1:0];
    if (!off0_ok) begin
      slot_a = '0;
    end else if (slot_sum >= SUM_W'(CAPACITY)) begin
      slot_a = SLOT_W'(slot_sum - SUM_W'(CAPACITY));
    end else begin
      slot_a = slot_sum[SLOT_W-1:0];
    end
  end

  always_comb begin
    drain         = (s1_action_r == SBR_ACT_DRAIN);
    new_end       = !drain && s1_fin_r && !end_known_r;
    end_known_nxt = end_known_r || new_end;
    end_index_nxt = new_end ? (s1_idx_r + SBR_IDX_W'(s1_has_r)) : end_index_r;
    room_ext      = RW'(s1_room_r);
    room_eff      = (room_ext > RW'(CAPACITY)) ? RW'(CAPACITY) : room_ext;
    off           = s1_idx_r - next_index_r;
    in_win        = off < SBR_IDX_W'(room_eff);
    past_end      = end_known_nxt && (s1_idx_r >= end_index_nxt);
    store         = !drain && s1_has_r && !closed_r && in_win && !past_end && !valid_a_r;
    emit          = drain && !closed_r && valid_b_r;
    next_index_nxt = next_index_r + SBR_IDX_W'(emit);
    if (emit) begin
      next_slot_nxt = (next_slot_r == SLOT_W'(CAPACITY - 1)) ? '0 : next_slot_r + SLOT_W'(1);
    end else begin
      next_slot_nxt = next_slot_r;
    end
    pending_nxt = pending_r + CNT_W'(store) - CNT_W'(emit && (pending_r != '0));
    closed_nxt  = closed_r || (end_known_nxt && (next_index_nxt == end_index_nxt));
  end

  assign res_valid         = exec;
  assign res_out_valid     = emit;
  assign res_out_byte      = emit ? byte_b_r : '0;
  assign res_stream_closed = closed_nxt;
  assign res_pending_bytes = pending_nxt;

  // valid map write port: clearing pass, store, or drain
  always_comb begin
    slot_b = exec ? next_slot_nxt : next_slot_r;
    if (clear_r) begin
      vwr_en   = 1'b1;
      vwr_addr = clr_addr_r;
      vwr_data = 1'b0;
    end else if (exec && store) begin
      vwr_en   = 1'b1;
      vwr_addr = s1_slot_r;
      vwr_data = 1'b1;
    end else if (exec && emit) begin
      vwr_en   = 1'b1;
      vwr_addr = next_slot_r;
      vwr_data = 1'b0;
    end else begin
      vwr_en   = 1'b0;
      vwr_addr = next_slot_r;
      vwr_data = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (vwr_en) begin
      valid_map_r[vwr_addr] <= vwr_data;
    end
    if (accept) begin
      if (vwr_en && (vwr_addr == slot_a)) begin
        valid_a_r <= vwr_data;
      end else begin
        valid_a_r <= valid_map_r[slot_a];
      end
    end
    if (vwr_en && (vwr_addr == slot_b)) begin
      valid_b_r <= vwr_data;
    end else begin
      valid_b_r <= valid_map_r[slot_b];
    end
  end

  always_ff @(posedge clk) begin
    if (exec && store) begin
      byte_store_r[s1_slot_r] <= s1_val_r;
    end
    if (exec && store && (s1_slot_r == slot_b)) begin
      byte_b_r <= s1_val_r;
    end else begin
      byte_b_r <= byte_store_r[slot_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r    <= 1'b1;
      clr_addr_r <= '0;
    end else if (clear_r) begin
      if (clr_addr_r == SLOT_W'(CAPACITY - 1)) begin
        clear_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (exec) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action_r <= in_action;
      s1_idx_r    <= in_byte_index;
      s1_val_r    <= in_byte_value;
      s1_has_r    <= in_has_byte;
      s1_fin_r    <= in_final_mark;
      s1_room_r   <= in_stream_room;
      s1_slot_r   <= slot_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_index_r <= '0;
      next_slot_r  <= '0;
      pending_r    <= '0;
      end_known_r  <= 1'b0;
      end_index_r  <= '0;
      closed_r     <= 1'b0;
    end else if (exec) begin
      next_index_r <= next_index_nxt;
      next_slot_r  <= next_slot_nxt;
      pending_r    <= pending_nxt;
      end_known_r  <= end_known_nxt;
      end_index_r  <= end_index_nxt;
      closed_r     <= closed_nxt;
    end
  end

  `SBR_ASSERT(a_closed_sticky, $past(rst_n) && $past(closed_r) |-> closed_r, "closed flag dropped")
  `SBR_ASSERT(a_no_exec_in_clear, exec |-> !clear_r, "item executed during clearing pass")
  `SBR_ASSERT(a_drain_step, exec && emit |=> next_index_r == $past(next_index_r) + 64'd1, "emit did not advance next index")
  `SBR_ASSERT_ALWAYS(a_pending_bound, rst_n && $past(rst_n) |-> pending_r <= CNT_W'(CAPACITY), "pending count above capacity")

endmodule

### dv/tb_top.sv
// self-checking testbench for stream_byte_reassembler_top
// holds a scoreboard class that predicts every result, plus tasks that drive the block
// depends on sbr_pkg and the reassembler rtl
`timescale 1ns / 100ps

module tb_top
  import sbr_pkg::*;
();

  localparam int CAP         = SBR_CAPACITY;
  localparam int PEND_W      = $clog2(CAP + 1);
  localparam int PERIOD      = 10;
  localparam int N_RANDOM    = 1930;
  localparam int IDLE_LIMIT  = 50000;

  typedef struct packed {
    logic              emitted;
    logic [7:0]        data;
    logic              closed;
    logic [PEND_W-1:0] pending;
  } emit_t;

  typedef struct {
    sbr_action_t           action;
    logic [SBR_IDX_W-1:0]  idx;
    logic [7:0]            value;
    logic                  has_byte;
    logic                  final_mark;
    logic [SBR_ROOM_W-1:0] room;
  } seg_item_t;

  class reassembled_stream_check;
    bit [7:0]             byte_store [CAP];
    bit                   valid_map [CAP];
    bit [SBR_IDX_W-1:0]   next_index;
    bit [PEND_W-1:0]      pending;
    bit                   end_known;
    bit [SBR_IDX_W-1:0]   end_index;
    bit                   closed;
    emit_t                expected_emits[$];
    int                   mismatch_count;

    function void take_item(seg_item_t it);
      emit_t              want;
      bit [SBR_IDX_W-1:0] off;
      bit [PEND_W-1:0]    win;
      int unsigned        s;
      want = '0;
      if (it.action == SBR_ACT_SEGMENT) begin
        if (it.final_mark && !end_known) begin
          end_known = 1'b1;
          end_index = it.idx + SBR_IDX_W'(it.has_byte);
        end
        win = (it.room > CAP) ? PEND_W'(CAP) : PEND_W'(it.room);
        off = it.idx - next_index;
        s = 32'(it.idx % CAP);
        if (it.has_byte && !closed && off < win && !(end_known && it.idx >= end_index)
            && !valid_map[s]) begin
          byte_store[s] = it.value;
          valid_map[s] = 1'b1;
          pending++;
        end
      end else if (!closed) begin
        s = 32'(next_index % CAP);
        if (valid_map[s]) begin
          want.emitted = 1'b1;
          want.data = byte_store[s];
          valid_map[s] = 1'b0;
          next_index++;
          if (pending > 0) pending--;
        end
      end
      if (end_known && next_index == end_index) closed = 1'b1;
      want.closed = closed;
      want.pending = pending;
      expected_emits.push_back(want);
    endfunction

    function void flag(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_emit(logic ov, logic [7:0] ob, logic cl, logic [PEND_W-1:0] pb);
      emit_t want;
      if (expected_emits.size() == 0) begin
        flag($sformatf("unexpected result valid=%0b byte=%02h closed=%0b pending=%0d",
                       ov, ob, cl, pb));
        return;
      end
      want = expected_emits.pop_front();
      if (want.emitted !== ov || want.data !== ob || want.closed !== cl
          || want.pending !== pb)
        flag($sformatf("expected valid=%0b byte=%02h closed=%0b pending=%0d, got %0b %02h %0b %0d",
                       want.emitted, want.data, want.closed, want.pending, ov, ob, cl, pb));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  sbr_action_t           in_action = SBR_ACT_SEGMENT;
  logic [SBR_IDX_W-1:0]  in_byte_index = '0;
  logic [7:0]            in_byte_value = '0;
  logic                  in_has_byte = 1'b0;
  logic                  in_final_mark = 1'b0;
  logic [SBR_ROOM_W-1:0] in_stream_room = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_out_valid;
  logic [7:0]            out_out_byte;
  logic                  out_stream_closed;
  logic [PEND_W-1:0]     out_pending_bytes;

  reassembled_stream_check chk;
  int                      idle_cycles = 0;
  int                      stall_mode = 0;
  logic [7:0]              cyc = '0;

  stream_byte_reassembler_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_byte_index     (in_byte_index),
    .in_byte_value     (in_byte_value),
    .in_has_byte       (in_has_byte),
    .in_final_mark     (in_final_mark),
    .in_stream_room    (in_stream_room),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_out_valid     (out_out_valid),
    .out_out_byte      (out_out_byte),
    .out_stream_closed (out_stream_closed),
    .out_pending_bytes (out_pending_bytes)
  );

  always #(PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 8'd1;
    if (cyc == 8'd0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= (cyc[3:0] < 4'd5);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
      chk.check_emit(out_out_valid, out_out_byte, out_stream_closed, out_pending_bytes);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic transfer(input seg_item_t it);
    in_valid       <= 1'b1;
    in_action      <= it.action;
    in_byte_index  <= it.idx;
    in_byte_value  <= it.value;
    in_has_byte    <= it.has_byte;
    in_final_mark  <= it.final_mark;
    in_stream_room <= it.room;
    do @(posedge clk); while (in_stall !== 1'b0);
    chk.take_item(it);
  endtask

  task automatic put_seg(input logic [SBR_IDX_W-1:0] idx, input logic [7:0] value,
                         input logic [SBR_ROOM_W-1:0] room, input logic has = 1'b1);
    seg_item_t it;
    it = '{SBR_ACT_SEGMENT, idx, value, has, 1'b0, room};
    transfer(it);
  endtask

  task automatic drain_tick();
    seg_item_t it;
    it = '{SBR_ACT_DRAIN, {$urandom, $urandom}, 8'($urandom), 1'($urandom),
           1'($urandom), SBR_ROOM_W'($urandom)};
    transfer(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (chk.expected_emits.size() != 0);
  endtask

  function automatic logic [SBR_ROOM_W-1:0] pick_room();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return SBR_ROOM_W'(CAP);
    if (r < 85) return SBR_ROOM_W'($urandom_range(64, CAP - 1));
    if (r < 95) return SBR_ROOM_W'($urandom_range(CAP + 1, 8191));
    return SBR_ROOM_W'($urandom_range(0, 3));
  endfunction

  function automatic seg_item_t random_item();
    seg_item_t            it;
    int unsigned          p;
    logic [SBR_IDX_W-1:0] nx;
    nx = chk.next_index;
    it = '{SBR_ACT_SEGMENT, {$urandom, $urandom}, 8'($urandom), 1'b1, 1'b0, pick_room()};
    if ($urandom_range(0, 99) < 40) begin
      it.action = SBR_ACT_DRAIN;
      it.has_byte = 1'($urandom_range(0, 1));
      it.final_mark = 1'($urandom_range(0, 1));
      it.room = SBR_ROOM_W'($urandom);
      return it;
    end
    p = $urandom_range(0, 99);
    if (p < 35) begin
      it.idx = nx + $urandom_range(0, 3);
    end else if (p < 70) begin
      it.idx = nx + $urandom_range(0, 63);
    end else if (p < 78) begin
      it.idx = nx + $urandom_range(CAP - 6, CAP + 4);
      it.room = SBR_ROOM_W'($urandom_range(CAP, 8191));
    end else if (p < 85) begin
      it.room = SBR_ROOM_W'($urandom_range(0, 200));
      it.idx = nx + it.room - $urandom_range(0, 1);
    end else if (p < 90) begin
      it.idx = nx - $urandom_range(1, 16);
    end else if (p < 97) begin
      if (p < 94) it.idx = {$urandom, $urandom};
      else begin
        it.idx = nx + $urandom_range(0, 8);
        it.has_byte = 1'b0;
      end
    end else begin
      it.idx = nx + $urandom_range(0, 15);
    end
    if (chk.end_known && $urandom_range(0, 29) == 0) it.final_mark = 1'b1;
    return it;
  endfunction

  function automatic seg_item_t stream_end_item(bit behind);
    seg_item_t            it;
    logic [SBR_IDX_W-1:0] nx;
    int unsigned          len;
    int unsigned          back;
    nx = chk.next_index;
    it = '{SBR_ACT_SEGMENT, '0, 8'($urandom), 1'($urandom), 1'b1, pick_room()};
    if (behind) begin
      if ($urandom_range(0, 1) == 0) begin
        // end index wraps to zero
        it.idx = '1;
        it.has_byte = 1'b1;
      end else begin
        back = (nx > 50) ? 50 : int'(nx);
        it.idx = nx - $urandom_range(2, back);
      end
    end else begin
      len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (len == 0) it.has_byte = 1'b0;
      it.idx = nx + len - it.has_byte;
    end
    return it;
  endfunction

  initial begin
    seg_item_t item;
    int        end_at;
    bit        end_behind;
    int        burst_left;
    int        gap;

    chk = new();
    end_at = N_RANDOM - $urandom_range(200, 300);
    end_behind = ($urandom_range(0, 5) == 0);
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    drain_tick();
    put_seg(0, 8'hFF, 13'(CAP));
    put_seg(0, 8'h00, 13'(CAP));
    drain_tick();
    drain_tick();
    put_seg(0, 8'h11, 13'(CAP));
    put_seg(1, 8'h00, 13'd0);
    put_seg(1, 8'h00, 13'd1);
    put_seg(2, 8'h77, 13'd1);
    put_seg(64'(CAP), 8'hA5, 13'h1FFF);
    put_seg(64'(CAP + 1), 8'h5A, 13'h1FFF);
    put_seg('1, 8'hC3, 13'(CAP));
    put_seg(2, 8'h3C, 13'(CAP), 1'b0);
    drain_tick();
    put_seg(2, 8'h5A, 13'(CAP + 1));
    drain_tick();

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == end_at) item = stream_end_item(end_behind);
      else item = random_item();
      transfer(item);
      if (n % 450 == 449) begin
        wait_drained();
      end else if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(80, 200)
                                                 : $urandom_range(1, 30);
        gap = $urandom_range(1, 12);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end

    in_valid <= 1'b0;
    while (chk.expected_emits.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (chk.mismatch_count == 0 && chk.expected_emits.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/sbr_pkg.sv
design/sbr_out_reg.sv
design/sbr_core.sv
design/stream_byte_reassembler_top.sv
dv/tb_top.sv
